[hdl/gregorian_date_calculator_defines.svh]
// Assertion macros for the date calculator.
`ifndef GREGORIAN_DATE_CALCULATOR_DEFINES_SVH
`define GREGORIAN_DATE_CALCULATOR_DEFINES_SVH

`ifndef SYNTH
// Checked outside reset.
`define GDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define GDC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define GDC_ASSERT(label, prop, msg)
`define GDC_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[hdl/gdc_pkg.sv]
package gdc_pkg;

  localparam logic [13:0] YearMin     = 14'd1700;
  localparam logic [13:0] YearMax     = 14'd9999;
  localparam logic [6:0]  YearMinQ100 = 7'd17;
  // floor(y / 100) = (y * Recip100) >> Recip100Shift for all 14-bit y
  localparam logic [12:0] Recip100      = 13'd5243;
  localparam int          Recip100Shift = 19;
  // serial day number of 1700-03-01
  localparam logic [21:0] SerialBase  = 22'd620912;

  localparam int InDataW  = 56;
  localparam int OutDataW = 64;

  typedef struct packed {
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [7:0]  q100;
  } gdc_raw_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        leap;
    logic [13:0] ys;     // year on a March-based count
    logic [6:0]  q100s;  // ys / 100
  } gdc_date_t;

  typedef struct packed {
    logic        first_valid;
    logic [13:0] next_year;
    logic [3:0]  next_month;
    logic [4:0]  next_day;
    logic [2:0]  quarter;
    logic        leap_year;
    logic [8:0]  day_of_year;
  } gdc_info_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    if (m == 4'd2) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

  // days before the month in a January-based year, common year
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] v;
    case (m)
      4'd1:    v = 9'd0;
      4'd2:    v = 9'd31;
      4'd3:    v = 9'd59;
      4'd4:    v = 9'd90;
      4'd5:    v = 9'd120;
      4'd6:    v = 9'd151;
      4'd7:    v = 9'd181;
      4'd8:    v = 9'd212;
      4'd9:    v = 9'd243;
      4'd10:   v = 9'd273;
      4'd11:   v = 9'd304;
      4'd12:   v = 9'd334;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // days before the month in a March-based year, month index 0 = March
  function automatic logic [8:0] march_offset(input logic [3:0] ms);
    logic [8:0] v;
    case (ms)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd92;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd184;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd245;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd337;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] quarter_of(input logic [3:0] m);
    logic [2:0] q;
    if (m <= 4'd3) begin
      q = 3'd1;
    end else if (m <= 4'd6) begin
      q = 3'd2;
    end else if (m <= 4'd9) begin
      q = 3'd3;
    end else begin
      q = 3'd4;
    end
    return q;
  endfunction

endpackage

[hdl/gregorian_date_calculator.sv]
// Gregorian date calculator. Takes one pair of dates per transfer and returns one result
// per transfer at a sustained rate of one pair per clock while the output is not stalled;
// the pipeline has five register stages (year / 100, validity and leap, serial day and
// next date, difference, weekday). Each stage advances whenever its successor has room,
// so bubbles close up under back-pressure. A date outside 1700-03-01 .. 9999-12-31
// or not on the calendar is replaced by 1700-03-01; the day after 9999-12-31 stays
// 9999-12-31, and days_between is 0 unless the second date is later than the first.
`include "gregorian_date_calculator_defines.svh"

module gregorian_date_calculator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // first_year, first_month, first_day, second_year, second_month, second_day
  input  logic [gdc_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // first_valid, next_year, next_month, next_day, quarter, leap_year,
  // day_of_year, day_of_week, days_between, zero fill
  output logic [gdc_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  assign rdy5 = !v5_q || m_axis_tready_i;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready_o = rdy1;
  assign m_axis_tvalid_o = v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // ---------------- stage 1: unpack, year / 100 ----------------
  gdc_pkg::gdc_raw_t raw_d [2];
  gdc_pkg::gdc_raw_t raw_q [2];
  logic [26:0]       prod100 [2];

  always_comb begin
    raw_d[0].year  = s_axis_tdata_i[13:0];
    raw_d[0].month = s_axis_tdata_i[20:14];
    raw_d[0].day   = s_axis_tdata_i[27:21];
    raw_d[1].year  = s_axis_tdata_i[41:28];
    raw_d[1].month = s_axis_tdata_i[48:42];
    raw_d[1].day   = s_axis_tdata_i[55:49];
    for (int i = 0; i < 2; i++) begin
      prod100[i]    = 27'(raw_d[i].year) * 27'(gdc_pkg::Recip100);
      raw_d[i].q100 = prod100[i][gdc_pkg::Recip100Shift +: 8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      raw_q[0] <= raw_d[0];
      raw_q[1] <= raw_d[1];
    end
  end

  // ---------------- stage 2: leap, validity, substitution ----------------
  gdc_pkg::gdc_date_t date_d [2];
  gdc_pkg::gdc_date_t date_q [2];
  logic               ok [2];
  logic               fv_q;
  logic [6:0]         r100 [2];
  logic               lp [2];
  logic [4:0]         ml2 [2];
  logic [14:0]        m100 [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      m100[i] = 15'(raw_q[i].q100) * 15'd100;
      r100[i] = 7'(15'(raw_q[i].year) - m100[i]);
      lp[i]   = ((raw_q[i].year[1:0] == 2'd0) && (r100[i] != 7'd0)) ||
                ((r100[i] == 7'd0) && (raw_q[i].q100[1:0] == 2'd0));
      ml2[i]  = gdc_pkg::month_len(raw_q[i].month[3:0], lp[i]);
      ok[i]   = (raw_q[i].year >= gdc_pkg::YearMin) && (raw_q[i].year <= gdc_pkg::YearMax) &&
                (raw_q[i].month >= 7'd1) && (raw_q[i].month <= 7'd12) &&
                (raw_q[i].day != 7'd0) && (raw_q[i].day <= 7'(ml2[i])) &&
                !((raw_q[i].year == gdc_pkg::YearMin) && (raw_q[i].month < 7'd3));
      if (ok[i]) begin
        date_d[i].year  = raw_q[i].year;
        date_d[i].month = raw_q[i].month[3:0];
        date_d[i].day   = raw_q[i].day[4:0];
        date_d[i].leap  = lp[i];
        if (raw_q[i].month <= 7'd2) begin
          // January and February belong to the previous March-based year
          date_d[i].ys    = raw_q[i].year - 14'd1;
          date_d[i].q100s = (r100[i] == 7'd0) ? 7'(raw_q[i].q100 - 8'd1)
                                              : 7'(raw_q[i].q100);
        end else begin
          date_d[i].ys    = raw_q[i].year;
          date_d[i].q100s = 7'(raw_q[i].q100);
        end
      end else begin
        date_d[i].year  = gdc_pkg::YearMin;
        date_d[i].month = 4'd3;
        date_d[i].day   = 5'd1;
        date_d[i].leap  = 1'b0;
        date_d[i].ys    = gdc_pkg::YearMin;
        date_d[i].q100s = gdc_pkg::YearMinQ100;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      date_q[0] <= date_d[0];
      date_q[1] <= date_d[1];
      fv_q      <= ok[0];
    end
  end

  // ---------------- stage 3: serial day, next date, ordinal day ----------------
  gdc_pkg::gdc_info_t info_d, info3_q, info4_q, info5_q;
  logic [22:0]        acc [2];
  logic [3:0]         ms [2];
  logic [21:0]        ser_q [2];
  logic [4:0]         ml3;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      ms[i]  = (date_q[i].month >= 4'd3) ? date_q[i].month - 4'd3 : date_q[i].month + 4'd9;
      acc[i] = 23'(date_q[i].ys) * 23'd365 + 23'(date_q[i].ys[13:2])
             + 23'(date_q[i].q100s[6:2]) + 23'(gdc_pkg::march_offset(ms[i]))
             + 23'(date_q[i].day) - 23'(date_q[i].q100s) - 23'd1;
    end

    ml3                = gdc_pkg::month_len(date_q[0].month, date_q[0].leap);
    info_d.first_valid = fv_q;
    info_d.next_year   = date_q[0].year;
    info_d.next_month  = date_q[0].month;
    info_d.next_day    = date_q[0].day;
    if (date_q[0].day < ml3) begin
      info_d.next_day = date_q[0].day + 5'd1;
    end else if (date_q[0].month < 4'd12) begin
      info_d.next_month = date_q[0].month + 4'd1;
      info_d.next_day   = 5'd1;
    end else if (date_q[0].year < gdc_pkg::YearMax) begin
      info_d.next_year  = date_q[0].year + 14'd1;
      info_d.next_month = 4'd1;
      info_d.next_day   = 5'd1;
    end
    info_d.quarter     = gdc_pkg::quarter_of(date_q[0].month);
    info_d.leap_year   = date_q[0].leap;
    info_d.day_of_year = gdc_pkg::days_before(date_q[0].month) + 9'(date_q[0].day)
                       + 9'(date_q[0].leap && (date_q[0].month > 4'd2));
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      ser_q[0] <= acc[0][21:0];
      ser_q[1] <= acc[1][21:0];
      info3_q  <= info_d;
    end
  end

  // ---------------- stage 4: difference, offset from base ----------------
  logic [21:0] diff_q, rel_q;

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      diff_q  <= (ser_q[1] > ser_q[0]) ? ser_q[1] - ser_q[0] : 22'd0;
      rel_q   <= ser_q[0] - gdc_pkg::SerialBase;
      info4_q <= info3_q;
    end
  end

  // ---------------- stage 5: weekday ----------------
  // 8 == 1 mod 7: add octal digits, then fold twice
  logic [5:0]  oct_sum;
  logic [3:0]  fold1;
  logic [2:0]  fold2;
  logic [2:0]  dow_d, dow_q;
  logic [21:0] diff5_q;

  always_comb begin
    oct_sum = 6'd0;
    for (int k = 0; k < 7; k++) begin
      oct_sum = oct_sum + 6'(rel_q[3*k +: 3]);
    end
    oct_sum = oct_sum + 6'(rel_q[21]);
    fold1   = 4'(oct_sum[5:3]) + 4'(oct_sum[2:0]);
    fold2   = fold1[2:0] + 3'(fold1[3]);
    dow_d   = (fold2 == 3'd7) ? 3'd1 : fold2 + 3'd1;
  end

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      dow_q   <= dow_d;
      diff5_q <= diff_q;
      info5_q <= info4_q;
    end
  end

  assign m_axis_tdata_o = {2'b00, diff5_q, dow_q, info5_q.day_of_year, info5_q.leap_year,
                           info5_q.quarter, info5_q.next_day, info5_q.next_month,
                           info5_q.next_year, info5_q.first_valid};

  `GDC_ASSERT(a_accept_fills_stage1, s_axis_tvalid_i && s_axis_tready_o |=> v1_q, "accepted transfer lost at stage 1")
  `GDC_ASSERT_ALWAYS(a_invalid_next_date, v5_q && !info5_q.first_valid |-> info5_q.next_year == gdc_pkg::YearMin && info5_q.next_month == 4'd3 && info5_q.next_day == 5'd2, "substituted date gives wrong next date")
  `GDC_ASSERT(a_doy_leap, v5_q && (info5_q.day_of_year == 9'd366) |-> info5_q.leap_year, "day 366 in a common year")

endmodule
